/* src/pcl_pkg.sv */
// command and status codes shared by the positional character list
`default_nettype none

package pcl_pkg;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* src/pcl_ram.sv */
// single write port, single registered read port entry store
`default_nettype none

module pcl_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/positional_char_list_top.sv */
// ordered byte list with insert, delete, find, read and clear commands
// no entry is walked for clear, unknown codes, refused requests, delete at the end or find on
// an empty list; read, find and delete walk their entries and then drain the store read;
// insert walks and drains unless it goes at the end, and then writes the new byte
// one request at a time: the next request can be taken from the cycle after the result is loaded;
// a single store read port walks one entry per cycle
// reset clears the entry count and the result valid flag; stored bytes are undefined
`default_nettype none

module positional_char_list_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pcl_pkg::CMD_W-1:0]       cmd,
  input  wire logic [pcl_pkg::POS_W-1:0]       position,
  input  wire logic [pcl_pkg::VAL_W-1:0]       value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [pcl_pkg::STATUS_W-1:0]    status,
  output logic      [pcl_pkg::POS_W-1:0]       found_position,
  output logic      [pcl_pkg::VAL_W-1:0]       read_value,
  output logic      [pcl_pkg::POS_W-1:0]       entry_count
);

  import pcl_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW + 1 : POS_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  logic [LW-1:0] len;
  logic [LW-1:0] res_len;
  status_t res_status;
  logic [POS_W-1:0] res_found;
  logic [VAL_W-1:0] res_rd;
  cmd_t cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [AW-1:0] idx;
  logic [AW-1:0] last;
  logic pv;
  logic [AW-1:0] pa;

  logic in_accept;
  logic [CW-1:0] posc;
  logic [CW-1:0] lenc;
  logic [AW-1:0] pos_idx;
  logic we;
  logic [AW-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic re;
  logic [VAL_W-1:0] rdata;
  logic load;

  assign in_stall = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign posc = CW'(position);
  assign lenc = CW'(len);
  assign pos_idx = AW'(pos_q) - AW'(1);
  assign load = (state == S_DONE) && (!out_valid || !out_stall);

  assign re = (state == S_RUN);
  assign we = (pv && (cmd_q == CMD_INSERT || cmd_q == CMD_DELETE)) || (state == S_PUT);

  always_comb begin
    if (state == S_PUT) begin
      waddr = pos_idx;
      wdata = val_q;
    end else begin
      waddr = (cmd_q == CMD_INSERT) ? pa + AW'(1) : pa - AW'(1);
      wdata = rdata;
    end
  end

  pcl_ram #(
    .DEPTH(CAPACITY),
    .AW(AW),
    .DW(VAL_W)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .re(re),
    .raddr(idx),
    .rdata(rdata)
  );

  // read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == S_RUN);
    end
    pa <= idx;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_DONE;
            case (cmd_t'(cmd))
              CMD_INSERT: begin
                if (posc != '0 && posc <= lenc + CW'(1) && len < LW'(CAPACITY)) begin
                  state <= (posc <= lenc) ? S_RUN : S_PUT;
                end
              end
              CMD_DELETE: begin
                if (posc != '0 && posc < lenc) begin
                  state <= S_RUN;
                end
              end
              CMD_FIND: begin
                if (len != '0) begin
                  state <= S_RUN;
                end
              end
              CMD_READ: begin
                if (posc != '0 && posc <= lenc) begin
                  state <= S_RUN;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RUN: begin
          if (idx == last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= (cmd_q == CMD_INSERT) ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture, walk bounds and result fields
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q <= cmd_t'(cmd);
      pos_q <= position;
      val_q <= value;
      res_len <= len;
      res_status <= ST_OK;
      res_found <= '0;
      res_rd <= '0;
      idx <= '0;
      last <= '0;
      case (cmd_t'(cmd))
        CMD_INSERT: begin
          if (posc == '0 || posc > lenc + CW'(1)) begin
            res_status <= ST_BADPOS;
          end else if (len >= LW'(CAPACITY)) begin
            res_status <= ST_FULL;
          end else begin
            res_len <= len + LW'(1);
            idx <= AW'(len - LW'(1));
            last <= AW'(position) - AW'(1);
          end
        end
        CMD_DELETE: begin
          if (posc == '0 || posc > lenc) begin
            res_status <= ST_BADPOS;
          end else begin
            res_len <= len - LW'(1);
            idx <= AW'(position);
            last <= AW'(len - LW'(1));
          end
        end
        CMD_FIND: begin
          res_status <= ST_NOTFOUND;
          last <= AW'(len - LW'(1));
        end
        CMD_READ: begin
          if (posc == '0 || posc > lenc) begin
            res_status <= ST_BADPOS;
          end else begin
            idx <= AW'(position) - AW'(1);
            last <= AW'(position) - AW'(1);
          end
        end
        CMD_CLEAR: begin
          res_len <= '0;
        end
        default: begin
          res_len <= len;
        end
      endcase
    end else begin
      if (state == S_RUN && idx != last) begin
        idx <= (cmd_q == CMD_INSERT) ? idx - AW'(1) : idx + AW'(1);
      end
      if (pv && cmd_q == CMD_FIND && res_status == ST_NOTFOUND && rdata == val_q) begin
        res_status <= ST_OK;
        res_found <= POS_W'(pa) + POS_W'(1);
      end
      if (pv && cmd_q == CMD_READ) begin
        res_rd <= rdata;
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (load) begin
      len <= res_len;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= res_status;
      found_position <= res_found;
      read_value <= res_rd;
      entry_count <= POS_W'(res_len);
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(CAPACITY))
    else $error("entry count above capacity");

  a_len_only_on_load: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) |=> $stable(len))
    else $error("entry count changed outside result load");

  a_put_only_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> (cmd_q == CMD_INSERT))
    else $error("store write of request value for non-insert");

  a_walk_cmd: assert property (@(posedge clk) disable iff (rst)
    pv |-> (cmd_q == CMD_INSERT || cmd_q == CMD_DELETE || cmd_q == CMD_FIND
            || cmd_q == CMD_READ))
    else $error("store walk for a command that needs none");

  a_load_frees_input: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && !in_stall))
    else $error("result load did not return to idle");
`endif

endmodule

`default_nettype wire
